// ===== src/yoot_pkg.sv =====
package yoot_pkg;

    // Fixed-point layout of the datapath.
    localparam int TRIG_BITS = 14;
    localparam int CW        = 33;  // center difference
    localparam int TW        = 36;  // rotated center difference, x and z
    localparam int RW        = 19;  // relative rotation entry
    localparam int MW        = 18;  // magnitude of a rotation entry
    localparam int HW        = 24;  // half extent
    localparam int WW        = 58;  // projections and radii
    localparam int NSTG      = 8;   // pipeline stages, output register included

    localparam int IN_W  = 200;
    localparam int OUT_W = 56;

    localparam logic signed [15:0] TRIG_ONE = 16'sd16384;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_HALF_X   = 3'd3,
        REG_HALF_Y   = 3'd4,
        REG_HALF_Z   = 3'd5,
        REG_COS_YAW  = 3'd6,
        REG_SIN_YAW  = 3'd7
    } reg_idx_t;

    // Magnitude of a signed value, widened to the compare width.
    function automatic logic [WW-1:0] mag_w(input logic signed [WW-1:0] v);
        return v[WW-1] ? WW'(-v) : WW'(v);
    endfunction

endpackage

// ===== src/yaw_obb_overlap_test_core.sv =====
// Yaw-only oriented box overlap test, separating axis form.
//
// The first box sits in eight APB registers (center, half extents, cos and
// sin of yaw); writes complete when psel, penable and pwrite are high, and
// pready is always high. Registers must be written only while no item is
// in flight, which the block does not enforce. Each s_ item carries the
// second box; each m_ item carries the hit flag and the least-overlap face
// normal of the second box, signed by relative centers, or zero on a miss.
//
// The datapath is an eight-stage pipeline with the output register as its
// last stage. One item is taken per cycle while s_tready is high.
// Each stage holds its item while the one after it is full and stalled,
// so a stall of m_tready backs up stage by stage and empty stages keep
// filling; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register reset values: unit half extents, zero center and zero yaw.
module yaw_obb_overlap_test_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // other_center_x, other_center_y, other_center_z, other_half_x,
    // other_half_y, other_half_z, other_cos_yaw, other_sin_yaw
    input  logic [yoot_pkg::IN_W-1:0]     s_tdata,
    // Result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, normal_x, normal_y, normal_z, zero pad
    output logic [yoot_pkg::OUT_W-1:0]    m_tdata
);
    import yoot_pkg::*;

    // Configuration registers.
    logic signed [31:0]   my_center_x_reg, my_center_y_reg, my_center_z_reg;
    logic [HW-1:0]        my_half_x_reg, my_half_y_reg, my_half_z_reg;
    logic signed [15:0]   my_cos_yaw_reg, my_sin_yaw_reg;
    reg_idx_t             cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_center_x_reg <= '0;
            my_center_y_reg <= '0;
            my_center_z_reg <= '0;
            my_half_x_reg   <= HW'(65536);
            my_half_y_reg   <= HW'(65536);
            my_half_z_reg   <= HW'(65536);
            my_cos_yaw_reg  <= TRIG_ONE;
            my_sin_yaw_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CENTER_X: my_center_x_reg <= pwdata;
                REG_CENTER_Y: my_center_y_reg <= pwdata;
                REG_CENTER_Z: my_center_z_reg <= pwdata;
                REG_HALF_X:   my_half_x_reg   <= pwdata[HW-1:0];
                REG_HALF_Y:   my_half_y_reg   <= pwdata[HW-1:0];
                REG_HALF_Z:   my_half_z_reg   <= pwdata[HW-1:0];
                REG_COS_YAW:  my_cos_yaw_reg  <= pwdata[15:0];
                REG_SIN_YAW:  my_sin_yaw_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (cfg_idx)
            REG_CENTER_X: prdata = my_center_x_reg;
            REG_CENTER_Y: prdata = my_center_y_reg;
            REG_CENTER_Z: prdata = my_center_z_reg;
            REG_HALF_X:   prdata = {8'd0, my_half_x_reg};
            REG_HALF_Y:   prdata = {8'd0, my_half_y_reg};
            REG_HALF_Z:   prdata = {8'd0, my_half_z_reg};
            REG_COS_YAW:  prdata = {16'd0, my_cos_yaw_reg};
            REG_SIN_YAW:  prdata = {16'd0, my_sin_yaw_reg};
            default:      prdata = '0;
        endcase
    end

    // Input fields.
    logic signed [31:0] in_cx, in_cy, in_cz;
    logic [HW-1:0]      in_hx, in_hy, in_hz;
    logic signed [15:0] in_cos, in_sin;

    assign in_cx  = s_tdata[31:0];
    assign in_cy  = s_tdata[63:32];
    assign in_cz  = s_tdata[95:64];
    assign in_hx  = s_tdata[119:96];
    assign in_hy  = s_tdata[143:120];
    assign in_hz  = s_tdata[167:144];
    assign in_cos = s_tdata[183:168];
    assign in_sin = s_tdata[199:184];

    // Pipeline flow control: a stage loads when it is empty or drains.
    logic [NSTG:1]   v_reg, v_next, v_in;
    logic [NSTG+1:1] stg_en;

    always_comb begin
        stg_en[NSTG+1] = m_tready;
        for (int k = NSTG; k >= 1; k--) begin
            stg_en[k] = !v_reg[k] || stg_en[k+1];
        end
        v_in   = {v_reg[NSTG-1:1], s_tvalid};
        v_next = (stg_en[NSTG:1] & v_in) | (~stg_en[NSTG:1] & v_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = stg_en[1];
    assign m_tvalid = v_reg[NSTG];

    // Stage 1: center difference and trig products.
    logic signed [CW-1:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic signed [31:0]   s1_pcc_reg, s1_pss_reg, s1_pcs_reg, s1_psc_reg;
    logic [HW-1:0]        s1_hx_reg, s1_hy_reg, s1_hz_reg;
    logic signed [15:0]   s1_cos_reg, s1_sin_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[1]) begin
            s1_dx_reg  <= CW'(in_cx) - CW'(my_center_x_reg);
            s1_dy_reg  <= CW'(in_cy) - CW'(my_center_y_reg);
            s1_dz_reg  <= CW'(in_cz) - CW'(my_center_z_reg);
            s1_pcc_reg <= my_cos_yaw_reg * in_cos;
            s1_pss_reg <= my_sin_yaw_reg * in_sin;
            s1_pcs_reg <= my_cos_yaw_reg * in_sin;
            s1_psc_reg <= my_sin_yaw_reg * in_cos;
            s1_hx_reg  <= in_hx;
            s1_hy_reg  <= in_hy;
            s1_hz_reg  <= in_hz;
            s1_cos_reg <= in_cos;
            s1_sin_reg <= in_sin;
        end
    end

    // Stage 2: round the relative rotation, multiply the center difference.
    logic signed [32:0]     s2_csum, s2_dsum;
    logic signed [RW-1:0]   s2_c_reg, s2_d_reg;
    logic signed [CW+15:0]  s2_m0_reg, s2_m1_reg, s2_m2_reg, s2_m3_reg;
    logic signed [CW-1:0]   s2_dy_reg;
    logic [2:0]             s2_gt_reg;
    logic [HW:0]            s2_sy_reg;
    logic [HW-1:0]          s2_hx_reg, s2_hz_reg;
    logic signed [15:0]     s2_cos_reg, s2_sin_reg;

    always_comb begin
        s2_csum = 33'(s1_pcc_reg) + 33'(s1_pss_reg) + 33'sd8192;
        s2_dsum = 33'(s1_pcs_reg) - 33'(s1_psc_reg) + 33'sd8192;
    end

    always_ff @(posedge aclk) begin
        if (stg_en[2]) begin
            s2_c_reg   <= s2_csum[32:TRIG_BITS];
            s2_d_reg   <= s2_dsum[32:TRIG_BITS];
            s2_m0_reg  <= s1_dx_reg * my_cos_yaw_reg;
            s2_m1_reg  <= s1_dz_reg * my_sin_yaw_reg;
            s2_m2_reg  <= s1_dx_reg * my_sin_yaw_reg;
            s2_m3_reg  <= s1_dz_reg * my_cos_yaw_reg;
            s2_dy_reg  <= s1_dy_reg;
            s2_gt_reg  <= {s1_dz_reg > 0, s1_dy_reg > 0, s1_dx_reg > 0};
            s2_sy_reg  <= (HW+1)'(my_half_y_reg) + (HW+1)'(s1_hy_reg);
            s2_hx_reg  <= s1_hx_reg;
            s2_hz_reg  <= s1_hz_reg;
            s2_cos_reg <= s1_cos_reg;
            s2_sin_reg <= s1_sin_reg;
        end
    end

    // Stage 3: round the rotated center difference, rotation magnitudes.
    logic signed [CW+16:0]  s3_xsum, s3_zsum;
    logic signed [TW-1:0]   s3_tx_reg, s3_tz_reg;
    logic signed [CW-1:0]   s3_ty_reg;
    logic signed [RW-1:0]   s3_c_reg, s3_d_reg;
    logic [MW-1:0]          s3_ac_reg, s3_ad_reg;
    logic [2:0]             s3_gt_reg;
    logic [HW:0]            s3_sy_reg;
    logic [HW-1:0]          s3_hx_reg, s3_hz_reg;
    logic signed [15:0]     s3_cos_reg, s3_sin_reg;

    always_comb begin
        s3_xsum = (CW+17)'(s2_m0_reg) - (CW+17)'(s2_m1_reg) + (CW+17)'(8192);
        s3_zsum = (CW+17)'(s2_m2_reg) + (CW+17)'(s2_m3_reg) + (CW+17)'(8192);
    end

    always_ff @(posedge aclk) begin
        if (stg_en[3]) begin
            s3_tx_reg  <= s3_xsum[CW+16:TRIG_BITS];
            s3_tz_reg  <= s3_zsum[CW+16:TRIG_BITS];
            s3_ty_reg  <= s2_dy_reg;
            s3_c_reg   <= s2_c_reg;
            s3_d_reg   <= s2_d_reg;
            s3_ac_reg  <= MW'(mag_w(WW'(s2_c_reg)));
            s3_ad_reg  <= MW'(mag_w(WW'(s2_d_reg)));
            s3_gt_reg  <= s2_gt_reg;
            s3_sy_reg  <= s2_sy_reg;
            s3_hx_reg  <= s2_hx_reg;
            s3_hz_reg  <= s2_hz_reg;
            s3_cos_reg <= s2_cos_reg;
            s3_sin_reg <= s2_sin_reg;
        end
    end

    // Stage 4: projection and radius products.
    logic signed [TW+RW-1:0] s4_txc_reg, s4_tzd_reg, s4_txd_reg, s4_tzc_reg;
    logic signed [CW+RW-1:0] s4_tyd_reg, s4_tyc_reg;
    logic [HW+MW-1:0]        s4_bxc_reg, s4_bzd_reg, s4_bxd_reg, s4_bzc_reg;
    logic [HW+MW-1:0]        s4_axc_reg, s4_azd_reg, s4_axd_reg, s4_azc_reg;
    logic [HW+MW:0]          s4_syd_reg, s4_syc_reg;
    logic [WW-1:0]           s4_mtx_reg, s4_mty_reg, s4_mtz_reg;
    logic [2:0]              s4_gt_reg;
    logic [HW:0]             s4_sy_reg;
    logic [HW-1:0]           s4_hx_reg, s4_hz_reg;
    logic signed [15:0]      s4_cos_reg, s4_sin_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[4]) begin
            s4_txc_reg <= s3_tx_reg * s3_c_reg;
            s4_tzd_reg <= s3_tz_reg * s3_d_reg;
            s4_txd_reg <= s3_tx_reg * s3_d_reg;
            s4_tzc_reg <= s3_tz_reg * s3_c_reg;
            s4_tyd_reg <= s3_ty_reg * s3_d_reg;
            s4_tyc_reg <= s3_ty_reg * s3_c_reg;
            s4_bxc_reg <= s3_hx_reg * s3_ac_reg;
            s4_bzd_reg <= s3_hz_reg * s3_ad_reg;
            s4_bxd_reg <= s3_hx_reg * s3_ad_reg;
            s4_bzc_reg <= s3_hz_reg * s3_ac_reg;
            s4_axc_reg <= my_half_x_reg * s3_ac_reg;
            s4_azd_reg <= my_half_z_reg * s3_ad_reg;
            s4_axd_reg <= my_half_x_reg * s3_ad_reg;
            s4_azc_reg <= my_half_z_reg * s3_ac_reg;
            s4_syd_reg <= s3_sy_reg * s3_ad_reg;
            s4_syc_reg <= s3_sy_reg * s3_ac_reg;
            s4_mtx_reg <= mag_w(WW'(s3_tx_reg));
            s4_mty_reg <= mag_w(WW'(s3_ty_reg));
            s4_mtz_reg <= mag_w(WW'(s3_tz_reg));
            s4_gt_reg  <= s3_gt_reg;
            s4_sy_reg  <= s3_sy_reg;
            s4_hx_reg  <= s3_hx_reg;
            s4_hz_reg  <= s3_hz_reg;
            s4_cos_reg <= s3_cos_reg;
            s4_sin_reg <= s3_sin_reg;
        end
    end

    // Stage 5: sums of the seven distinct axis tests.
    // The remaining cross axes repeat one of these or never separate.
    logic signed [WW-1:0] s5_g0_reg, s5_g2_reg;
    logic [WW-1:0]        s5_lf0_reg, s5_lf1_reg, s5_lf2_reg, s5_lx0_reg, s5_lx2_reg;
    logic [WW-1:0]        s5_rf0_reg, s5_rf1_reg, s5_rf2_reg, s5_rg0_reg, s5_rg2_reg;
    logic [WW-1:0]        s5_rx0_reg, s5_rx2_reg;
    logic [2:0]           s5_gt_reg;
    logic signed [15:0]   s5_cos_reg, s5_sin_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[5]) begin
            s5_g0_reg  <= WW'(s4_txc_reg) - WW'(s4_tzd_reg);
            s5_g2_reg  <= WW'(s4_txd_reg) + WW'(s4_tzc_reg);
            s5_lx0_reg <= mag_w(WW'(s4_tyd_reg));
            s5_lx2_reg <= mag_w(WW'(s4_tyc_reg));
            s5_lf0_reg <= s4_mtx_reg << TRIG_BITS;
            s5_lf1_reg <= s4_mty_reg << TRIG_BITS;
            s5_lf2_reg <= s4_mtz_reg << TRIG_BITS;
            s5_rf0_reg <= (WW'(my_half_x_reg) << TRIG_BITS) + WW'(s4_bxc_reg)
                          + WW'(s4_bzd_reg);
            s5_rf1_reg <= WW'(s4_sy_reg) << TRIG_BITS;
            s5_rf2_reg <= (WW'(my_half_z_reg) << TRIG_BITS) + WW'(s4_bxd_reg)
                          + WW'(s4_bzc_reg);
            s5_rg0_reg <= WW'(s4_axc_reg) + WW'(s4_azd_reg)
                          + (WW'(s4_hx_reg) << TRIG_BITS);
            s5_rg2_reg <= WW'(s4_axd_reg) + WW'(s4_azc_reg)
                          + (WW'(s4_hz_reg) << TRIG_BITS);
            s5_rx0_reg <= WW'(s4_syd_reg);
            s5_rx2_reg <= WW'(s4_syc_reg);
            s5_gt_reg  <= s4_gt_reg;
            s5_cos_reg <= s4_cos_reg;
            s5_sin_reg <= s4_sin_reg;
        end
    end

    // Stage 6: magnitudes of the second box face projections.
    logic [WW-1:0]      s6_ag0_reg, s6_ag2_reg;
    logic [WW-1:0]      s6_lf0_reg, s6_lf1_reg, s6_lf2_reg, s6_lx0_reg, s6_lx2_reg;
    logic [WW-1:0]      s6_rf0_reg, s6_rf1_reg, s6_rf2_reg, s6_rg0_reg, s6_rg2_reg;
    logic [WW-1:0]      s6_rx0_reg, s6_rx2_reg;
    logic [2:0]         s6_gt_reg;
    logic signed [15:0] s6_cos_reg, s6_sin_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[6]) begin
            s6_ag0_reg <= mag_w(s5_g0_reg);
            s6_ag2_reg <= mag_w(s5_g2_reg);
            s6_lf0_reg <= s5_lf0_reg;
            s6_lf1_reg <= s5_lf1_reg;
            s6_lf2_reg <= s5_lf2_reg;
            s6_lx0_reg <= s5_lx0_reg;
            s6_lx2_reg <= s5_lx2_reg;
            s6_rf0_reg <= s5_rf0_reg;
            s6_rf1_reg <= s5_rf1_reg;
            s6_rf2_reg <= s5_rf2_reg;
            s6_rg0_reg <= s5_rg0_reg;
            s6_rg2_reg <= s5_rg2_reg;
            s6_rx0_reg <= s5_rx0_reg;
            s6_rx2_reg <= s5_rx2_reg;
            s6_gt_reg  <= s5_gt_reg;
            s6_cos_reg <= s5_cos_reg;
            s6_sin_reg <= s5_sin_reg;
        end
    end

    // Stage 7: separation tests and overlaps on the second box faces.
    logic               s7_sep;
    logic               s7_hit_reg;
    logic [WW-1:0]      s7_ov0_reg, s7_ov1_reg, s7_ov2_reg;
    logic [2:0]         s7_gt_reg;
    logic signed [15:0] s7_cos_reg, s7_sin_reg;

    always_comb begin
        s7_sep = (s6_lf0_reg > s6_rf0_reg) || (s6_lf1_reg > s6_rf1_reg)
              || (s6_lf2_reg > s6_rf2_reg) || (s6_ag0_reg > s6_rg0_reg)
              || (s6_ag2_reg > s6_rg2_reg) || (s6_lx0_reg > s6_rx0_reg)
              || (s6_lx2_reg > s6_rx2_reg);
    end

    always_ff @(posedge aclk) begin
        if (stg_en[7]) begin
            s7_hit_reg <= !s7_sep;
            s7_ov0_reg <= s6_rg0_reg - s6_ag0_reg;
            s7_ov1_reg <= s6_rf1_reg - s6_lf1_reg;
            s7_ov2_reg <= s6_rg2_reg - s6_ag2_reg;
            s7_gt_reg  <= s6_gt_reg;
            s7_cos_reg <= s6_cos_reg;
            s7_sin_reg <= s6_sin_reg;
        end
    end

    // Stage 8: least-overlap face, signed normal, output register.
    logic [WW-1:0]      s8_best;
    logic [1:0]         s8_axis;
    logic               s8_neg;
    logic signed [15:0] s8_nx, s8_ny, s8_nz;
    logic               out_hit_reg;
    logic signed [15:0] out_nx_reg, out_ny_reg, out_nz_reg;

    always_comb begin
        s8_axis = 2'd0;
        s8_best = s7_ov0_reg;
        if (s7_ov1_reg < s8_best) begin
            s8_axis = 2'd1;
            s8_best = s7_ov1_reg;
        end
        if (s7_ov2_reg < s8_best) begin
            s8_axis = 2'd2;
        end
        s8_neg = s7_gt_reg[s8_axis];
        s8_nx  = '0;
        s8_ny  = '0;
        s8_nz  = '0;
        case (s8_axis)
            2'd0: begin
                s8_nx = s7_cos_reg;
                s8_nz = -s7_sin_reg;
            end
            2'd1: begin
                s8_ny = TRIG_ONE;
            end
            default: begin
                s8_nx = s7_sin_reg;
                s8_nz = s7_cos_reg;
            end
        endcase
        if (s8_neg) begin
            s8_nx = -s8_nx;
            s8_ny = -s8_ny;
            s8_nz = -s8_nz;
        end
        if (!s7_hit_reg) begin
            s8_nx = '0;
            s8_ny = '0;
            s8_nz = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[8]) begin
            out_hit_reg <= s7_hit_reg;
            out_nx_reg  <= s8_nx;
            out_ny_reg  <= s8_ny;
            out_nz_reg  <= s8_nz;
        end
    end

    assign m_tdata = {7'd0, out_nz_reg, out_ny_reg, out_nx_reg, out_hit_reg};

endmodule

// ===== src/yoot_checker.sv =====
module yoot_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [yoot_pkg::OUT_W-1:0] m_tdata
);
    import yoot_pkg::*;

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A miss carries a zero normal.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[48:1] == '0)
        else $error("normal not zero without hit");

    // A normal along y has no horizontal part.
    a_y_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32:17] != '0 |-> m_tdata[16:1] == '0 && m_tdata[48:33] == '0)
        else $error("y normal mixed with horizontal parts");

    // The input side never backs up while the output holds no result.
    a_in_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

endmodule

bind yaw_obb_overlap_test_core yoot_checker u_yoot_checker (.*);
